FILE: src/dmn_pkg.sv
// Shared types and codes for the distributed mutex node.
`default_nettype none

package dmn_pkg;

  localparam int unsigned SRC_W     = 4;
  localparam int unsigned SEQ_IO_W  = 16;
  localparam int unsigned TDATA_W   = 24;
  localparam int unsigned TUSER_W   = 3;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 5;

  typedef enum logic [2:0] {
    OP_LREQ = 3'd0,
    OP_LREL = 3'd1,
    OP_RREQ = 3'd2,
    OP_RREP = 3'd3,
    OP_LFIN = 3'd4,
    OP_RFIN = 3'd5,
    OP_BAD  = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ACT_REQ   = 3'd0,
    ACT_REPLY = 3'd1,
    ACT_GRANT = 3'd2,
    ACT_FIN   = 3'd3,
    ACT_DONE  = 3'd4,
    ACT_ERR   = 3'd5
  } act_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MY_INDEX    = 1'd0,
    REG_NUM_SERVERS = 1'd1
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BCAST,
    ST_RELEASE,
    ST_SINGLE
  } state_e;

  typedef struct packed {
    op_e                 op;
    logic [SRC_W-1:0]    src;
    logic [SEQ_IO_W-1:0] seq;
  } cmd_t;

  typedef struct packed {
    act_e                action;
    logic [SRC_W-1:0]    dest;
    logic [SEQ_IO_W-1:0] seq;
    logic                last;
  } res_t;

endpackage

`default_nettype wire

FILE: src/distributed_mutex_node.sv
// Top level of one distributed mutual exclusion node.
// A lone result passes from the single-result state into the output register; a broadcast
//   scans the node indices in order and may end with a trailing grant or all-done, and a
//   release scans deferred flags in index order. The back end accepts only when idle.
// Input queue holds two requests, so the input side takes up to two requests during a scan.
// Reset is asynchronous, active low; it clears the control state and deferred flags at once.
`default_nettype none

module distributed_mutex_node
  import dmn_pkg::*;
#(
  parameter int unsigned MAX_NODES = 16,
  parameter int unsigned SEQ_BITS  = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [TDATA_W-1:0]    s_axis_tdata,  // source_node[3:0], seq_in[19:4], zero pad
  input  wire logic [TUSER_W-1:0]    s_axis_tuser,  // req_type[2:0]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [TDATA_W-1:0]         m_axis_tdata,  // dest_node[3:0], seq_out[19:4], zero pad
  output logic [TUSER_W-1:0]         m_axis_tuser,  // action[2:0]
  output logic                       m_axis_tlast
);

  cmd_t cmd;
  logic cmd_valid, cmd_ready;
  res_t res;

  dmn_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_o         (cmd),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready)
  );

  dmn_back #(
    .MAX_NODES (MAX_NODES),
    .SEQ_BITS  (SEQ_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .res_o       (res),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {4'd0, res.seq, res.dest};
  assign m_axis_tuser = res.action;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

FILE: src/dmn_front.sv
// Front end: decodes incoming requests and queues them for the back end.
`default_nettype none

module dmn_front
  import dmn_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [TDATA_W-1:0] s_axis_tdata,  // source_node[3:0], seq_in[19:4], zero pad
  input  wire logic [TUSER_W-1:0] s_axis_tuser,  // req_type[2:0]
  output cmd_t                    cmd_o,
  output logic                    cmd_valid_o,
  input  wire logic               cmd_ready_i
);

  cmd_t       fifo_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       dec;
  logic       push, pop;

  always_comb begin
    dec.src = s_axis_tdata[SRC_W-1:0];
    dec.seq = s_axis_tdata[SRC_W+SEQ_IO_W-1:SRC_W];
    unique case (s_axis_tuser)
      3'd0:    dec.op = OP_LREQ;
      3'd1:    dec.op = OP_LREL;
      3'd2:    dec.op = OP_RREQ;
      3'd3:    dec.op = OP_RREP;
      3'd4:    dec.op = OP_LFIN;
      3'd5:    dec.op = OP_RFIN;
      default: dec.op = OP_BAD;
    endcase
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign cmd_valid_o   = (cnt_q != 2'd0);
  assign cmd_o         = fifo_q[rd_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= dec;
    end
  end

endmodule

`default_nettype wire

FILE: src/dmn_back.sv
// Back end: protocol state, sequencer for broadcasts and deferred replies, output register.
`default_nettype none

module dmn_back
  import dmn_pkg::*;
#(
  parameter int unsigned MAX_NODES = 16,
  parameter int unsigned SEQ_BITS  = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  cmd_t                       cmd_i,
  input  wire logic                  cmd_valid_i,
  output logic                       cmd_ready_o,
  output res_t                       res_o,
  output logic                       res_valid_o,
  input  wire logic                  res_ready_i
);

  localparam int unsigned IDX_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned SCAN_W   = (IDX_W > SRC_W) ? IDX_W : SRC_W;
  localparam int unsigned NODE_LIM = (MAX_NODES < 16) ? MAX_NODES : 16;

  function automatic logic [CFG_DATA_W-1:0] clamp_cnt(input logic [CFG_DATA_W-1:0] ns);
    logic [CFG_DATA_W-1:0] c;
    begin
      c = ns;
      if (c == '0) c = CFG_DATA_W'(1);
      if (c > CFG_DATA_W'(NODE_LIM)) c = CFG_DATA_W'(NODE_LIM);
      return c;
    end
  endfunction

  state_e                state_q, state_d;
  logic [SRC_W-1:0]      my_q, my_d;
  logic [CFG_DATA_W-1:0] ns_q, ns_d;
  logic [SEQ_BITS-1:0]   own_q, own_d;
  logic [SEQ_BITS-1:0]   high_q, high_d;
  logic                  pend_q, pend_d;
  logic [3:0]            outst_q, outst_d;
  logic [MAX_NODES-1:0]  flags_q, flags_d;
  logic [CFG_DATA_W-1:0] ca_q, ca_d;
  logic                  fin_q, fin_d;
  logic                  ovalid_q, ovalid_d;
  res_t                  out_q, out_d;
  logic [SCAN_W-1:0]     scan_q, scan_d;
  act_e                  bc_act_q, bc_act_d;
  logic                  tail_q, tail_d;
  act_e                  sgl_act_q, sgl_act_d;
  logic [SRC_W-1:0]      sgl_dest_q, sgl_dest_d;

  logic [CFG_DATA_W-1:0]        cnt, cm1, last_peer;
  logic                         has_peer, can_load, cmd_go, is_err, src_big, defer;
  logic [CFG_DATA_W-1:0]        ca_dec;
  logic                         fin_done;
  logic [SEQ_BITS+SEQ_IO_W-1:0] seq_ext;
  logic [SEQ_BITS-1:0]          seq_n, own_inc;
  logic [SEQ_BITS+15:0]         own_ext;
  logic [SRC_W-1:0]             bc_idx;
  logic                         bc_emit, bc_end, bc_step;
  logic [IDX_W-1:0]             rl_ix;
  logic                         rl_hit, rl_last;
  logic [MAX_NODES-1:0]         rl_rest;

  // decisions shared by next-state and datapath logic
  always_comb begin
    cnt       = clamp_cnt(ns_q);
    cm1       = cnt - CFG_DATA_W'(1);
    last_peer = ({1'b0, my_q} == cm1) ? (cnt - CFG_DATA_W'(2)) : cm1;
    has_peer  = (cnt >= CFG_DATA_W'(2)) || (my_q != '0);
    can_load  = !ovalid_q || res_ready_i;
    cmd_go    = (state_q == ST_IDLE) && cmd_valid_i;
    seq_ext   = {SEQ_BITS'(0), cmd_i.seq};
    seq_n     = seq_ext[SEQ_BITS-1:0];
    own_inc   = (high_q == '1) ? high_q : high_q + SEQ_BITS'(1);
    own_ext   = {16'd0, own_q};
    src_big   = {1'b0, cmd_i.src} >= cnt;
    defer     = pend_q && ((seq_n > own_q) || ((seq_n == own_q) && (cmd_i.src > my_q)));
    ca_dec    = (ca_q == '0) ? ca_q : ca_q - CFG_DATA_W'(1);
    fin_done  = (ca_dec == '0);
    is_err    = fin_q || (cmd_i.op == OP_BAD)
             || ((cmd_i.op == OP_LREQ) && pend_q)
             || ((cmd_i.op == OP_LREL) && !pend_q)
             || ((cmd_i.op == OP_RREQ) && src_big)
             || ((cmd_i.op == OP_RREP) && (!pend_q || (outst_q == '0)));
    bc_idx    = scan_q[SRC_W-1:0];
    bc_emit   = (bc_idx != my_q);
    bc_end    = ({1'b0, bc_idx} == cm1);
    bc_step   = !bc_emit || can_load;
    rl_ix     = scan_q[IDX_W-1:0];
    rl_hit    = flags_q[rl_ix];
    rl_rest   = flags_q & ~(MAX_NODES'(1) << rl_ix);
    rl_last   = (rl_rest == '0);
  end

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign res_o       = out_q;
  assign res_valid_o = ovalid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_go) begin
          priority if (is_err) begin
            state_d = ST_SINGLE;
          end else begin
            unique case (cmd_i.op)
              OP_LREQ: state_d = has_peer ? ST_BCAST : ST_SINGLE;
              OP_LREL: state_d = (flags_q != '0) ? ST_RELEASE : ST_IDLE;
              OP_RREQ: state_d = defer ? ST_IDLE : ST_SINGLE;
              OP_RREP: state_d = (outst_q == 4'd1) ? ST_SINGLE : ST_IDLE;
              OP_LFIN: state_d = has_peer ? ST_BCAST : (fin_done ? ST_SINGLE : ST_IDLE);
              OP_RFIN: state_d = fin_done ? ST_SINGLE : ST_IDLE;
              default: state_d = ST_SINGLE;
            endcase
          end
        end
      end
      ST_BCAST: begin
        if (bc_step && bc_end) state_d = tail_q ? ST_SINGLE : ST_IDLE;
      end
      ST_RELEASE: begin
        if (rl_hit && can_load && rl_last) state_d = ST_IDLE;
      end
      ST_SINGLE: begin
        if (can_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    my_d       = my_q;
    ns_d       = ns_q;
    own_d      = own_q;
    high_d     = high_q;
    pend_d     = pend_q;
    outst_d    = outst_q;
    flags_d    = flags_q;
    ca_d       = ca_q;
    fin_d      = fin_q;
    out_d      = out_q;
    scan_d     = scan_q;
    bc_act_d   = bc_act_q;
    tail_d     = tail_q;
    sgl_act_d  = sgl_act_q;
    sgl_dest_d = sgl_dest_q;
    ovalid_d   = res_ready_i ? 1'b0 : ovalid_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_go) begin
          scan_d     = '0;
          sgl_dest_d = '0;
          priority if (is_err) begin
            sgl_act_d = ACT_ERR;
          end else begin
            unique case (cmd_i.op)
              OP_LREQ: begin
                pend_d    = 1'b1;
                outst_d   = cm1[3:0];
                own_d     = own_inc;
                bc_act_d  = ACT_REQ;
                tail_d    = (cnt == CFG_DATA_W'(1));
                sgl_act_d = ACT_GRANT;
              end
              OP_LREL: begin
                pend_d = 1'b0;
              end
              OP_RREQ: begin
                if (seq_n > high_q) high_d = seq_n;
                if (defer) flags_d = flags_q | (MAX_NODES'(1) << cmd_i.src);
                sgl_act_d  = ACT_REPLY;
                sgl_dest_d = cmd_i.src;
              end
              OP_RREP: begin
                outst_d   = outst_q - 4'd1;
                sgl_act_d = ACT_GRANT;
              end
              OP_LFIN, OP_RFIN: begin
                ca_d      = ca_dec;
                fin_d     = fin_done;
                bc_act_d  = ACT_FIN;
                tail_d    = fin_done;
                sgl_act_d = ACT_DONE;
              end
              default: sgl_act_d = ACT_ERR;
            endcase
          end
        end
      end
      ST_BCAST: begin
        if (bc_emit && can_load) begin
          ovalid_d     = 1'b1;
          out_d.action = bc_act_q;
          out_d.dest   = bc_idx;
          out_d.seq    = (bc_act_q == ACT_REQ) ? own_ext[SEQ_IO_W-1:0] : '0;
          out_d.last   = ({1'b0, bc_idx} == last_peer) && !tail_q;
        end
        if (bc_step) scan_d = scan_q + SCAN_W'(1);
      end
      ST_RELEASE: begin
        if (rl_hit && can_load) begin
          ovalid_d     = 1'b1;
          out_d.action = ACT_REPLY;
          out_d.dest   = scan_q[SRC_W-1:0];
          out_d.seq    = '0;
          out_d.last   = rl_last;
          flags_d      = rl_rest;
        end
        if (!rl_hit || can_load) scan_d = scan_q + SCAN_W'(1);
      end
      ST_SINGLE: begin
        if (can_load) begin
          ovalid_d     = 1'b1;
          out_d.action = sgl_act_q;
          out_d.dest   = sgl_dest_q;
          out_d.seq    = '0;
          out_d.last   = 1'b1;
        end
      end
      default: ;
    endcase

    if (cfg_we_i) begin
      unique case (reg_e'(cfg_addr_i))
        REG_MY_INDEX: my_d = cfg_wdata_i[SRC_W-1:0];
        REG_NUM_SERVERS: begin
          ns_d = cfg_wdata_i;
          ca_d = clamp_cnt(cfg_wdata_i);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      my_q     <= '0;
      ns_q     <= CFG_DATA_W'(2);
      own_q    <= '0;
      high_q   <= '0;
      pend_q   <= 1'b0;
      outst_q  <= '0;
      flags_q  <= '0;
      ca_q     <= CFG_DATA_W'(2);
      fin_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      my_q     <= my_d;
      ns_q     <= ns_d;
      own_q    <= own_d;
      high_q   <= high_d;
      pend_q   <= pend_d;
      outst_q  <= outst_d;
      flags_q  <= flags_d;
      ca_q     <= ca_d;
      fin_q    <= fin_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    scan_q     <= scan_d;
    bc_act_q   <= bc_act_d;
    tail_q     <= tail_d;
    sgl_act_q  <= sgl_act_d;
    sgl_dest_q <= sgl_dest_d;
  end

endmodule

`default_nettype wire

FILE: src/dmn_checker.sv
// Port-level checker for the distributed mutex node, bound to the top level.
`default_nettype none

module dmn_checker
  import dmn_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               m_axis_tvalid,
  input wire logic               m_axis_tready,
  input wire logic [TDATA_W-1:0] m_axis_tdata,
  input wire logic [TUSER_W-1:0] m_axis_tuser,
  input wire logic               m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ACT_ERR) |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("error result not a lone empty result");

  a_grant_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tuser == ACT_GRANT) || (m_axis_tuser == ACT_DONE))
      |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("grant or all-done not final or carries data");

  a_seq_only_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ACT_REQ) |-> (m_axis_tdata[TDATA_W-1:SRC_W] == '0))
    else $error("sequence number on a non-request result");

endmodule

bind distributed_mutex_node dmn_checker u_dmn_checker (.*);

`default_nettype wire

FILE: sim/tb_distributed_mutex_node.sv
// Self-checking testbench for distributed_mutex_node: directed and random events vs. a predictor.
module tb_distributed_mutex_node;
  import dmn_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 30;
  localparam logic [15:0] SEQ_TOP      = 16'hFFFF;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata  = '0;
  logic [TUSER_W-1:0]    s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;
  logic [TUSER_W-1:0]    m_axis_tuser;
  logic                  m_axis_tlast;

  // node state as the testbench sees it
  logic [3:0]  cfg_self     = 4'd0;
  logic [4:0]  cfg_nodes    = 5'd2;
  logic [15:0] my_seq       = '0;
  logic [15:0] top_seq      = '0;
  logic        want_lock    = 1'b0;
  logic [3:0]  acks_left    = '0;
  logic [15:0] held_replies = '0;
  logic [4:0]  live_clients = 5'd2;
  logic        all_done     = 1'b0;

  cmd_t        events_to_send[$];
  cmd_t        on_wire;
  res_t        owed_results[$];
  res_t        step_out[$];

  int unsigned tx_gap      = 0;
  int unsigned rx_stall    = 0;
  int unsigned rx_wait     = 0;
  int unsigned hold_left   = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_starts = 0;
  int unsigned sent_items  = 0;
  int unsigned cycles      = 0;
  int          mismatches  = 0;
  bit          tx_calm     = 1'b0;
  bit          rx_calm     = 1'b0;

  distributed_mutex_node u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [4:0] node_span(logic [4:0] n);
    if (n == 5'd0) return 5'd1;
    if (n > 5'd16) return 5'd16;
    return n;
  endfunction

  function automatic void emit(act_e a, logic [3:0] d, logic [15:0] s);
    res_t r;
    r.action = a;
    r.dest   = d;
    r.seq    = s;
    r.last   = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void advance_node(cmd_t c);
    logic [4:0] span;
    span = node_span(cfg_nodes);
    step_out.delete();
    if (all_done || c.op > OP_RFIN) begin
      emit(ACT_ERR, 4'd0, 16'd0);
    end else begin
      case (c.op)
        OP_LREQ: begin
          if (want_lock) begin
            emit(ACT_ERR, 4'd0, 16'd0);
          end else begin
            want_lock = 1'b1;
            acks_left = 4'(span - 5'd1);
            my_seq    = (top_seq == SEQ_TOP) ? SEQ_TOP : top_seq + 16'd1;
            for (int i = 0; i < span; i++)
              if (i != cfg_self) emit(ACT_REQ, 4'(i), my_seq);
            if (acks_left == 4'd0) emit(ACT_GRANT, 4'd0, 16'd0);
          end
        end
        OP_LREL: begin
          if (!want_lock) begin
            emit(ACT_ERR, 4'd0, 16'd0);
          end else begin
            want_lock = 1'b0;
            for (int i = 0; i < 16; i++)
              if (held_replies[i]) emit(ACT_REPLY, 4'(i), 16'd0);
            held_replies = '0;
          end
        end
        OP_RREQ: begin
          if (c.src >= span) begin
            emit(ACT_ERR, 4'd0, 16'd0);
          end else begin
            if (c.seq > top_seq) top_seq = c.seq;
            // hold the reply while our own request has priority
            if (want_lock && (c.seq > my_seq || (c.seq == my_seq && c.src > cfg_self)))
              held_replies[c.src] = 1'b1;
            else
              emit(ACT_REPLY, c.src, 16'd0);
          end
        end
        OP_RREP: begin
          if (!want_lock || acks_left == 4'd0) begin
            emit(ACT_ERR, 4'd0, 16'd0);
          end else begin
            acks_left = acks_left - 4'd1;
            if (acks_left == 4'd0) emit(ACT_GRANT, 4'd0, 16'd0);
          end
        end
        default: begin
          if (c.op == OP_LFIN)
            for (int i = 0; i < span; i++)
              if (i != cfg_self) emit(ACT_FIN, 4'(i), 16'd0);
          if (live_clients != 5'd0) live_clients = live_clients - 5'd1;
          if (live_clients == 5'd0) begin
            all_done = 1'b1;
            emit(ACT_DONE, 4'd0, 16'd0);
          end
        end
      endcase
    end
    if (step_out.size() != 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) owed_results.push_back(step_out[i]);
  endfunction

  function automatic void match(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result();
    res_t want;
    if (owed_results.size() == 0) begin
      $error("result with nothing owed: action %0d dest %0d seq %0d",
             m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[19:4]);
      mismatches++;
    end else begin
      want = owed_results.pop_front();
      match("action", 16'(want.action), 16'(m_axis_tuser));
      match("dest_node", 16'(want.dest), 16'(m_axis_tdata[3:0]));
      match("seq_out", want.seq, m_axis_tdata[19:4]);
      match("last", 16'(want.last), 16'(m_axis_tlast));
    end
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_gap        <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) advance_node(on_wire);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap != 0) begin
          tx_gap        <= tx_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (events_to_send.size() != 0) begin
          on_wire = events_to_send.pop_front();
          s_axis_tuser  <= on_wire.op;
          s_axis_tdata  <= {4'd0, on_wire.seq, on_wire.src};
          s_axis_tvalid <= 1'b1;
          tx_gap        <= tx_calm ? 0 : $urandom_range(0, 8);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_stall      <= 0;
      hold_left     <= 0;
      hold_seen     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (hold_seen != hold_starts) begin
        hold_seen     <= hold_starts;
        hold_left     <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        rx_wait = rx_calm ? 0 : $urandom_range(0, 8);
        rx_stall      <= rx_wait;
        m_axis_tready <= (rx_wait == 0);
      end else if (rx_stall != 0) begin
        rx_stall      <= rx_stall - 1;
        m_axis_tready <= (rx_stall == 1);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_distributed_mutex_node: FAIL");
      $finish;
    end
  end

  task automatic post_at(op_e op, logic [3:0] src, logic [15:0] seq);
    cmd_t c;
    c.op  = op;
    c.src = src;
    c.seq = seq;
    events_to_send.push_back(c);
    sent_items++;
  endtask

  task automatic post(op_e op);
    post_at(op, 4'($urandom), 16'($urandom));
  endtask

  task automatic post_remote(logic [15:0] base);
    int         s;
    logic [3:0] who;
    s = int'(base) + int'($urandom_range(0, 4)) - 2;
    if ($urandom_range(0, 3) == 0) s = int'($urandom_range(0, base));
    if (s < 0) s = 0;
    if (s > 65535) s = 65535;
    if ($urandom_range(0, 9) == 0) who = 4'($urandom);
    else who = 4'($urandom_range(0, int'(node_span(cfg_nodes)) - 1));
    post_at(OP_RREQ, who, 16'(s));
  endtask

  task automatic settle();
    while (events_to_send.size() != 0 || s_axis_tvalid) @(negedge clk_i);
  endtask

  task automatic quiesce();
    settle();
    while (owed_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e r, logic [4:0] v);
    quiesce();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= r;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (r == REG_MY_INDEX) begin
      cfg_self = v[3:0];
    end else begin
      cfg_nodes    = v;
      live_clients = node_span(v);
    end
    @(negedge clk_i);
  endtask

  // one request/grant/release cycle with remote traffic mixed in
  task automatic lock_round();
    logic [15:0] base;
    int          acks;
    int          n;
    settle();
    base = (top_seq == SEQ_TOP) ? SEQ_TOP : top_seq + 16'd1;
    acks = int'(node_span(cfg_nodes)) - 1;
    if (want_lock) post(OP_LREL);
    repeat ($urandom_range(0, 2)) post_remote(base);
    post(OP_LREQ);
    repeat (acks) begin
      if ($urandom_range(0, 2) == 0) post_remote(base);
      post(OP_RREP);
    end
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(0, 5);
      post(op_e'(3'((n > 3) ? n + 2 : n)));
    end
    if (live_clients > 5'd3 && $urandom_range(0, 3) == 0)
      post($urandom_range(0, 1) ? OP_LFIN : OP_RFIN);
    if ($urandom_range(0, 7) != 0) post(OP_LREL);
  endtask

  initial begin
    logic [4:0]  self_v;
    logic [4:0]  nodes_v;
    int unsigned goal;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    post(OP_LREL);
    post(OP_RREP);
    post(OP_BAD);
    post_at(op_e'(3'd7), 4'hF, SEQ_TOP);
    post_at(OP_RREQ, 4'hF, SEQ_TOP);
    post_at(OP_RREQ, 4'd1, 16'd0);
    post_at(OP_LREQ, 4'hF, SEQ_TOP);
    post(OP_LREQ);
    post_at(OP_RREQ, 4'd1, 16'd1);
    post_at(OP_RREQ, 4'd0, 16'd0);
    post(OP_RREP);
    post(OP_RREP);
    post(OP_LREL);
    post(OP_RFIN);
    write_reg(REG_NUM_SERVERS, 5'd1);
    post(OP_LREQ);
    post(OP_LREL);
    write_reg(REG_MY_INDEX, 5'd15);
    write_reg(REG_NUM_SERVERS, 5'd16);
    post(OP_LREQ);
    post(OP_LREL);
    write_reg(REG_NUM_SERVERS, 5'd3);
    post(OP_LREQ);
    post(OP_LREL);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin self_v = 5'd0;  nodes_v = 5'd16; end
        1:       begin self_v = 5'd15; nodes_v = 5'd16; end
        2:       begin self_v = 5'd20; nodes_v = 5'd2;  end
        3:       begin self_v = 5'd0;  nodes_v = 5'd0;  end
        4:       begin self_v = 5'd9;  nodes_v = 5'd31; end
        5:       begin self_v = 5'd4;  nodes_v = 5'd5;  end
        6:       begin self_v = 5'd14; nodes_v = 5'd3;  end
        7:       begin self_v = 5'd1;  nodes_v = 5'd17; end
        default: begin self_v = 5'($urandom); nodes_v = 5'($urandom); end
      endcase
      write_reg(REG_MY_INDEX, self_v);
      write_reg(REG_NUM_SERVERS, nodes_v);
      tx_calm = ($urandom_range(0, 2) == 0);
      rx_calm = ($urandom_range(0, 2) == 0);
      // stall the result side long enough to back up the request side
      if (p == 1) begin
        tx_calm = 1'b1;
        hold_starts++;
      end
      goal = sent_items + PHASE_ITEMS;
      while (sent_items < goal) lock_round();
    end

    tx_calm = 1'b0;
    rx_calm = 1'b0;
    write_reg(REG_MY_INDEX, 5'd6);
    write_reg(REG_NUM_SERVERS, 5'd16);
    if (want_lock) post(OP_LREL);
    post_at(OP_RREQ, 4'd0, SEQ_TOP);
    post(OP_LREQ);
    post_at(OP_RREQ, 4'd9, SEQ_TOP);
    post_at(OP_RREQ, 4'd2, SEQ_TOP);
    post(OP_LREL);
    post(OP_LREQ);
    post(OP_LREL);

    write_reg(REG_NUM_SERVERS, 5'd16);
    repeat (15) post($urandom_range(0, 1) ? OP_LFIN : OP_RFIN);
    post(OP_LFIN);
    repeat (3) post(op_e'(3'($urandom_range(0, 7))));

    quiesce();
    if (mismatches == 0) begin
      $display("tb_distributed_mutex_node: PASS");
    end else begin
      $display("tb_distributed_mutex_node: FAIL");
    end
    $finish;
  end

endmodule
